@@ hdl/e2q_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and tables for the roll/pitch/yaw to quaternion core.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int unsigned AngleWidth = 16;
  localparam int unsigned QuatWidth = 16;
  localparam int unsigned CordicIterations = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned CordicSteps =
      (CordicIterations < AtanEntries) ? CordicIterations : AtanEntries;
  // Q.28 angle and Q.30 vector datapath widths
  localparam int unsigned ZWidth = 32;
  localparam int unsigned XyWidth = 32;
  localparam int unsigned TrigWidth = 17;
  localparam int unsigned Prod2Width = 34;
  localparam int unsigned Prod3Width = 51;
  localparam int unsigned SumWidth = 52;

  localparam logic signed [ZWidth-1:0] AngPi = 32'sd843314856;
  localparam logic signed [ZWidth-1:0] AngHalfPi = 32'sd421657428;
  localparam logic signed [XyWidth-1:0] CordicInvGain = 32'sd652032874;
  localparam logic signed [QuatWidth-1:0] Q14One = 16'sd16384;

  typedef logic signed [AngleWidth-1:0] angle_t;
  typedef logic signed [QuatWidth-1:0] quat_t;
  typedef logic signed [TrigWidth-1:0] trig_t;

  typedef struct packed {
    angle_t roll_angle;
    angle_t pitch_angle;
    angle_t yaw_angle;
  } angles_t;

  typedef struct packed {
    quat_t quat_w;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
  } quat_set_t;

  typedef struct packed {
    logic signed [XyWidth-1:0] x;
    logic signed [XyWidth-1:0] y;
    logic signed [ZWidth-1:0] z;
    logic flip;
  } cordic_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sincos_t;

  function automatic logic signed [ZWidth-1:0] atan_q28(input int unsigned idx);
    logic signed [ZWidth-1:0] r;
    case (idx)
      0: r = 32'sd210828714;
      1: r = 32'sd124459457;
      2: r = 32'sd65760959;
      3: r = 32'sd33381290;
      4: r = 32'sd16755422;
      5: r = 32'sd8385879;
      6: r = 32'sd4193963;
      7: r = 32'sd2097109;
      8: r = 32'sd1048571;
      9: r = 32'sd524287;
      default: r = 32'sd262144 >>> (idx - 10);
    endcase
    return r;
  endfunction

endpackage

@@ hdl/e2q_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_angle_if / e2q_quat_if
// Valid/ready channels carrying angle triples and quaternion results.
// ----------------------------------------------------------------------------
interface e2q_angle_if;
  import e2q_pkg::*;
  logic valid;
  logic ready;
  angles_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface e2q_quat_if;
  import e2q_pkg::*;
  logic valid;
  logic ready;
  quat_set_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hdl/e2q_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined half-angle sine/cosine: fold, one CORDIC step per stage, round.
// ----------------------------------------------------------------------------
module e2q_cordic (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  e2q_pkg::angle_t      angle_i,
  output e2q_pkg::sincos_t     sincos_o
);
  import e2q_pkg::*;

  cordic_t stage_q [CordicSteps+1];
  cordic_t fold_d;
  logic signed [ZWidth-1:0] z_half;
  logic signed [XyWidth-1:0] xr, yr;
  logic signed [XyWidth:0] cr_sum, sr_sum;

  // Halve and fold the angle into [-pi/2, pi/2]
  always_comb begin
    z_half = {{(ZWidth-AngleWidth-14){angle_i[AngleWidth-1]}}, angle_i, 14'b0};
    fold_d.x = CordicInvGain;
    fold_d.y = '0;
    fold_d.flip = 1'b0;
    fold_d.z = z_half;
    if (z_half > AngHalfPi) begin
      fold_d.z = z_half - AngPi;
      fold_d.flip = 1'b1;
    end else if (z_half < -AngHalfPi) begin
      fold_d.z = z_half + AngPi;
      fold_d.flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) stage_q[0] <= fold_d;
  end

  // One rotation step per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    cordic_t nxt_d;
    always_comb begin
      nxt_d = stage_q[i];
      if (!stage_q[i].z[ZWidth-1]) begin
        nxt_d.x = stage_q[i].x - (stage_q[i].y >>> i);
        nxt_d.y = stage_q[i].y + (stage_q[i].x >>> i);
        nxt_d.z = stage_q[i].z - atan_q28(i);
      end else begin
        nxt_d.x = stage_q[i].x + (stage_q[i].y >>> i);
        nxt_d.y = stage_q[i].y - (stage_q[i].x >>> i);
        nxt_d.z = stage_q[i].z + atan_q28(i);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) stage_q[i+1] <= nxt_d;
    end
  end

  // Apply the fold sign and round to Q.15
  always_comb begin
    xr = stage_q[CordicSteps].flip ? -stage_q[CordicSteps].x : stage_q[CordicSteps].x;
    yr = stage_q[CordicSteps].flip ? -stage_q[CordicSteps].y : stage_q[CordicSteps].y;
    cr_sum = {xr[XyWidth-1], xr} + (XyWidth+1)'(16384);
    sr_sum = {yr[XyWidth-1], yr} + (XyWidth+1)'(16384);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sincos_o.c <= cr_sum[TrigWidth+14:15];
      sincos_o.s <= sr_sum[TrigWidth+14:15];
    end
  end

endmodule

@@ hdl/e2q_combine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_combine
// Triple products, sums, rounding and saturation into Q1.14 in three stages.
// ----------------------------------------------------------------------------
module e2q_combine (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  e2q_pkg::sincos_t     roll_i,
  input  e2q_pkg::sincos_t     pitch_i,
  input  e2q_pkg::sincos_t     yaw_i,
  output e2q_pkg::quat_set_t   quat_o
);
  import e2q_pkg::*;

  logic signed [Prod2Width-1:0] cc_q, ss_q, sc_q, cs_q;
  trig_t sy_q, cy_q;
  logic signed [Prod3Width-1:0] p_q [8];
  logic signed [SumWidth-1:0] s_d [4];
  quat_t q_d [4];

  // Stage A: roll times pitch
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= roll_i.c * pitch_i.c;
      ss_q <= roll_i.s * pitch_i.s;
      sc_q <= roll_i.s * pitch_i.c;
      cs_q <= roll_i.c * pitch_i.s;
      sy_q <= yaw_i.s;
      cy_q <= yaw_i.c;
    end
  end

  // Stage B: times yaw
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= cc_q * cy_q;
      p_q[1] <= ss_q * sy_q;
      p_q[2] <= sc_q * cy_q;
      p_q[3] <= cs_q * sy_q;
      p_q[4] <= cs_q * cy_q;
      p_q[5] <= sc_q * sy_q;
      p_q[6] <= cc_q * sy_q;
      p_q[7] <= ss_q * cy_q;
    end
  end

  // Stage C: add, round to Q.14, saturate
  always_comb begin
    s_d[0] = SumWidth'(p_q[0]) + SumWidth'(p_q[1]);
    s_d[1] = SumWidth'(p_q[2]) - SumWidth'(p_q[3]);
    s_d[2] = SumWidth'(p_q[4]) + SumWidth'(p_q[5]);
    s_d[3] = SumWidth'(p_q[6]) - SumWidth'(p_q[7]);
    for (int k = 0; k < 4; k++) begin
      logic signed [SumWidth-1:0] r;
      logic signed [SumWidth-32:0] v;
      r = s_d[k] + (SumWidth'(1) <<< 30);
      v = r[SumWidth-1:31];
      if (v > (SumWidth-30)'(Q14One)) q_d[k] = Q14One;
      else if (v < -(SumWidth-30)'(Q14One)) q_d[k] = -Q14One;
      else q_d[k] = v[QuatWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quat_o.quat_w <= q_d[0];
      quat_o.quat_x <= q_d[1];
      quat_o.quat_y <= q_d[2];
      quat_o.quat_z <= q_d[3];
    end
  end

endmodule

@@ hdl/euler_to_quaternion_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// Roll/pitch/yaw (Q3.13 rad) to unit quaternion (Q1.14), fully pipelined.
//
// Usage: angles arrive on in_if (valid/ready), one transaction per triple;
// each produces exactly one quaternion transaction on out_if.
// Pipeline: one fold stage, one stage per CORDIC step, a rounding stage, two
// product stages and a sum/saturate stage that feeds the output register.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the per-step CORDIC stages and the two product stages, each of
// which takes a new item every cycle.
// Reset clears all valid bits; no data registers are reset.
// When the receiver stalls, the whole pipeline holds in place (ready is the
// downstream ready or an empty output slot), so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module euler_to_quaternion_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  e2q_angle_if.sink   in_if,
  e2q_quat_if.source  out_if
);
  import e2q_pkg::*;

  localparam int unsigned Latency = CordicSteps + 5;

  logic [Latency-1:0] vld_q;
  logic en;
  sincos_t sc_roll, sc_pitch, sc_yaw;

  // Advance when the output slot is free or being taken
  assign en = out_if.ready || !vld_q[Latency-1];
  assign in_if.ready = en;
  assign out_if.valid = vld_q[Latency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], in_if.valid};
    end
  end

  e2q_cordic u_roll (.clk_i, .en_i(en), .angle_i(in_if.data.roll_angle), .sincos_o(sc_roll));
  e2q_cordic u_pitch (.clk_i, .en_i(en), .angle_i(in_if.data.pitch_angle),
                      .sincos_o(sc_pitch));
  e2q_cordic u_yaw (.clk_i, .en_i(en), .angle_i(in_if.data.yaw_angle), .sincos_o(sc_yaw));

  e2q_combine u_combine (
    .clk_i,
    .en_i(en),
    .roll_i(sc_roll),
    .pitch_i(sc_pitch),
    .yaw_i(sc_yaw),
    .quat_o(out_if.data)
  );

  // A stalled result stays valid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");
  // Accepted input shows up valid at the head of the pipe
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> vld_q[0]) else $error("input lost");
  // Saturated range holds for quat_w
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.data.quat_w <= Q14One && out_if.data.quat_w >= -Q14One))
    else $error("w out of range");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives angle triples into euler_to_quaternion_core under random stalls on
// both channels and checks every quaternion against a bit-exact fixed-point
// CORDIC predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import e2q_pkg::*;

  localparam int unsigned LatencyCycles = 40;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomItems = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  e2q_angle_if angle_ch();
  e2q_quat_if quat_ch();

  euler_to_quaternion_core DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(angle_ch.sink),
    .out_if(quat_ch.source)
  );

  always #5 clk_i = ~clk_i;

  angles_t pending_angles[$];
  quat_set_t expected_quats[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 46;
  bit hold_send = 1'b0;
  bit in_taken = 1'b0;

  // Bit-exact half-angle sine/cosine in Q.15
  function automatic void half_sin_cos(input angle_t ang, output longint s,
                                       output longint c);
    longint z, x, y, dx, dy, ang_step;
    bit flip;
    z = longint'(ang) * 16384;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 421657428) begin
      z -= 843314856;
      flip = 1'b1;
    end else if (z < -421657428) begin
      z += 843314856;
      flip = 1'b1;
    end
    for (int i = 0; i < 16 && i < 24; i++) begin
      if (i < 10) begin
        case (i)
          0: ang_step = 210828714;
          1: ang_step = 124459457;
          2: ang_step = 65760959;
          3: ang_step = 33381290;
          4: ang_step = 16755422;
          5: ang_step = 8385879;
          6: ang_step = 4193963;
          7: ang_step = 2097109;
          8: ang_step = 1048571;
          default: ang_step = 524287;
        endcase
      end else begin
        ang_step = 262144 >>> (i - 10);
      end
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ang_step;
      end else begin
        x += dx;
        y -= dy;
        z += ang_step;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + 16384) >>> 15;
    s = (y + 16384) >>> 15;
  endfunction

  // Round a Q.45 sum to Q.14 and clamp to +-1.0
  function automatic quat_t round_clamp(input longint sum);
    longint v;
    v = (sum + (longint'(1) << 30)) >>> 31;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return quat_t'(v);
  endfunction

  function automatic quat_set_t predict_quat(input angles_t a);
    longint sr, cr, sp, cp, sy, cy;
    quat_set_t q;
    half_sin_cos(a.roll_angle, sr, cr);
    half_sin_cos(a.pitch_angle, sp, cp);
    half_sin_cos(a.yaw_angle, sy, cy);
    q.quat_w = round_clamp(cr * cp * cy + sr * sp * sy);
    q.quat_x = round_clamp(sr * cp * cy - cr * sp * sy);
    q.quat_y = round_clamp(cr * sp * cy + sr * cp * sy);
    q.quat_z = round_clamp(cr * cp * sy - sr * sp * cy);
    return q;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Append a triple to the pending queue
  task automatic add_pending(input angles_t a);
    pending_angles.insert(pending_angles.size(), a);
  endtask

  // Driver: present the next transaction, hold until it is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        void'(pending_angles.pop_front());
      end
      if (!angle_ch.valid || in_taken) begin
        if (pending_angles.size() > 0 &&
            !hold_send && $urandom_range(99) >= send_idle_pct) begin
          angle_ch.valid <= 1'b1;
          angle_ch.data <= pending_angles[0];
        end else begin
          angle_ch.valid <= 1'b0;
        end
      end
      quat_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on accepted inputs, check accepted results
  always @(posedge clk_i) begin
    quat_set_t want;
    in_taken = angle_ch.valid && angle_ch.ready;
    if (rst_ni) begin
      cycle_count++;
      if (in_taken) begin
        expected_quats.insert(expected_quats.size(), predict_quat(angle_ch.data));
      end
      if (quat_ch.valid && quat_ch.ready) begin
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          want = expected_quats.pop_front();
          if (quat_ch.data.quat_w !== want.quat_w)
            report_mismatch("quat_w", quat_ch.data.quat_w, want.quat_w);
          if (quat_ch.data.quat_x !== want.quat_x)
            report_mismatch("quat_x", quat_ch.data.quat_x, want.quat_x);
          if (quat_ch.data.quat_y !== want.quat_y)
            report_mismatch("quat_y", quat_ch.data.quat_y, want.quat_y);
          if (quat_ch.data.quat_z !== want.quat_z)
            report_mismatch("quat_z", quat_ch.data.quat_z, want.quat_z);
        end
      end
      if (cycle_count > CycleLimit) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic angle_t pick_angle();
    case ($urandom_range(5))
      0: return angle_t'($urandom_range(65535));
      1: return angle_t'(int'($urandom_range(25736)) - 12868);
      2: return angle_t'(int'($urandom_range(400)) - 200);
      3: return angle_t'(int'($urandom_range(200)) + 12768);
      4: return angle_t'(-int'($urandom_range(200)) - 12768);
      default: return angle_t'(int'($urandom_range(100)) + 25636);
    endcase
  endfunction

  // Phase loads: random triples, queued by the test under three idle mixes
  task automatic load_phase(input int unsigned count);
    angles_t a;
    for (int unsigned i = 0; i < count; i++) begin
      a.roll_angle = pick_angle();
      a.pitch_angle = pick_angle();
      a.yaw_angle = pick_angle();
      add_pending(a);
    end
  endtask

  task automatic wait_drain();
    while (pending_angles.size() != 0 || angle_ch.valid || expected_quats.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    angle_t corners[10];
    angles_t a;
    angle_ch.valid = 1'b0;
    angle_ch.data = '0;
    quat_ch.ready = 1'b0;
    corners = '{16'sd0, 16'sd32767, 16'sh8000, 16'sd1, -16'sd1,
                16'sd12868, 16'sd12869, -16'sd12868, -16'sd12869, 16'sd25736};
    for (int i = 0; i < 10; i++) begin
      a.roll_angle = corners[i];
      a.pitch_angle = corners[(i + 3) % 10];
      a.yaw_angle = corners[(i + 7) % 10];
      add_pending(a);
    end
    for (int i = 0; i < 10; i++) begin
      a = '0;
      a.roll_angle = corners[i];
      add_pending(a);
    end
    a.roll_angle = 16'sh5555;
    a.pitch_angle = 16'shAAAA;
    a.yaw_angle = 16'sh5555;
    add_pending(a);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    load_phase(RandomItems / 3);
    wait_drain();
    // Pause the sender while the next triples are queued
    hold_send = 1'b1;
    load_phase(50);
    repeat (30) @(posedge clk_i);
    hold_send = 1'b0;
    wait_drain();
    send_idle_pct = 46;
    recv_idle_pct = 27;
    load_phase(RandomItems / 3);
    wait_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_phase(RandomItems / 3);
    wait_drain();
    repeat (LatencyCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
